FILE: src/csed_pkg.sv
`timescale 1ns / 1ps

package csed_pkg;

	// Largest number of result items that one input character can cause.
	localparam int unsigned MAX_RESULTS = 4;

	localparam logic [11:0] COUNT_MAX = 12'hFFF;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_X  = 8'h78;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_TEXT  = 3'd1,
		PH_ESC   = 3'd2,
		PH_HEX0  = 3'd3,
		PH_HEX1  = 3'd4,
		PH_OCT   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_status;
		logic        status;
		logic [11:0] byte_count;
		logic        run_end;
	} out_item_t;

	// Everything one input character produces, handed from the front to the back.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [2:0]                  nbytes;
		logic                        has_status;
		logic                        status;
		logic [11:0]                 count;
	} bundle_t;

endpackage

FILE: src/csed_front.sv
`timescale 1ns / 1ps

module csed_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csed_pkg::in_item_t  in_item,
	input  logic                q_full,
	output logic                push,
	output csed_pkg::bundle_t   push_bundle
);

	csed_pkg::phase_t ph_q, ph_nx;
	logic [7:0]  held_q, held_nx;
	logic [5:0]  oval_q, oval_nx;
	logic        two_q, two_nx;
	logic        bad_q, bad_nx;
	logic [11:0] cnt_q, cnt_nx;
	logic        acc;

	// Hex digit value; bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = {1'b0, 4'(c[3:0] + 4'd9)};
		end
		return v;
	endfunction

	// Simple escapes; bit 8 set when the character names one.
	function automatic logic [8:0] simple_esc(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			8'h61:   r = {1'b1, 8'd7};
			8'h62:   r = {1'b1, 8'd8};
			8'h66:   r = {1'b1, 8'd12};
			8'h6E:   r = {1'b1, 8'd10};
			8'h72:   r = {1'b1, 8'd13};
			8'h74:   r = {1'b1, 8'd9};
			8'h76:   r = {1'b1, 8'd11};
			8'h5C, 8'h27, 8'h22, 8'h3F: r = {1'b1, c};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h37;
	endfunction

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= csed_pkg::PH_START;
			held_q <= '0;
			oval_q <= '0;
			two_q  <= 1'b0;
			bad_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (acc) begin
			ph_q   <= ph_nx;
			held_q <= held_nx;
			oval_q <= oval_nx;
			two_q  <= two_nx;
			bad_q  <= bad_nx;
			cnt_q  <= cnt_nx;
		end
	end

	always_comb begin
		logic [7:0]  c;
		logic [2:0]  n;
		logic [12:0] sum;
		logic        do_text;
		logic [8:0]  se;
		logic [4:0]  hv_c;
		logic [4:0]  hv_h;

		c       = in_item.ch;
		n       = 3'd0;
		do_text = 1'b0;
		se      = simple_esc(c);
		hv_c    = hex_val(c);
		hv_h    = hex_val(held_q);

		ph_nx   = ph_q;
		held_nx = held_q;
		oval_nx = oval_q;
		two_nx  = two_q;
		bad_nx  = bad_q;
		push_bundle = '0;

		if (ph_q == csed_pkg::PH_START) begin
			if (in_item.last_char) begin
				push_bundle.has_status = 1'b1;
				push_bundle.status     = 1'b1;
			end else begin
				bad_nx = (c != csed_pkg::CH_QUOTE);
				ph_nx  = csed_pkg::PH_TEXT;
			end
		end else if (!in_item.last_char) begin
			unique case (ph_q)
				csed_pkg::PH_ESC: begin
					if (se[8]) begin
						push_bundle.bytes[n[1:0]] = se[7:0]; n = n + 3'd1;
						ph_nx = csed_pkg::PH_TEXT;
					end else if (c == csed_pkg::CH_LOW_X) begin
						ph_nx = csed_pkg::PH_HEX0;
					end else if (is_oct(c)) begin
						oval_nx = {3'd0, c[2:0]};
						two_nx  = 1'b0;
						ph_nx   = csed_pkg::PH_OCT;
					end else begin
						push_bundle.bytes[n[1:0]] = csed_pkg::CH_BSLASH; n = n + 3'd1;
						do_text = 1'b1;
					end
				end
				csed_pkg::PH_HEX0: begin
					if (!hv_c[4]) begin
						held_nx = c;
						ph_nx   = csed_pkg::PH_HEX1;
					end else begin
						push_bundle.bytes[n[1:0]] = csed_pkg::CH_BSLASH; n = n + 3'd1;
						push_bundle.bytes[n[1:0]] = csed_pkg::CH_LOW_X;  n = n + 3'd1;
						do_text = 1'b1;
					end
				end
				csed_pkg::PH_HEX1: begin
					if (!hv_c[4]) begin
						push_bundle.bytes[n[1:0]] = {hv_h[3:0], hv_c[3:0]}; n = n + 3'd1;
						ph_nx = csed_pkg::PH_TEXT;
					end else begin
						push_bundle.bytes[n[1:0]] = csed_pkg::CH_BSLASH; n = n + 3'd1;
						push_bundle.bytes[n[1:0]] = csed_pkg::CH_LOW_X;  n = n + 3'd1;
						push_bundle.bytes[n[1:0]] = held_q;              n = n + 3'd1;
						do_text = 1'b1;
					end
					held_nx = '0;
				end
				csed_pkg::PH_OCT: begin
					if (is_oct(c)) begin
						if (two_q) begin
							push_bundle.bytes[n[1:0]] = {oval_q[4:0], c[2:0]}; n = n + 3'd1;
							oval_nx = '0;
							two_nx  = 1'b0;
							ph_nx   = csed_pkg::PH_TEXT;
						end else begin
							oval_nx = {oval_q[2:0], c[2:0]};
							two_nx  = 1'b1;
						end
					end else begin
						push_bundle.bytes[n[1:0]] = {2'd0, oval_q}; n = n + 3'd1;
						oval_nx = '0;
						two_nx  = 1'b0;
						do_text = 1'b1;
					end
				end
				default: do_text = 1'b1;
			endcase
			if (do_text) begin
				if (c == csed_pkg::CH_BSLASH) begin
					ph_nx = csed_pkg::PH_ESC;
				end else begin
					push_bundle.bytes[n[1:0]] = c; n = n + 3'd1;
					ph_nx = csed_pkg::PH_TEXT;
				end
			end
		end else begin
			// Closing character: resolve a pending escape, then report.
			unique case (ph_q)
				csed_pkg::PH_ESC: begin
					push_bundle.bytes[n[1:0]] = csed_pkg::CH_BSLASH; n = n + 3'd1;
				end
				csed_pkg::PH_HEX0: begin
					push_bundle.bytes[n[1:0]] = csed_pkg::CH_BSLASH; n = n + 3'd1;
					push_bundle.bytes[n[1:0]] = csed_pkg::CH_LOW_X;  n = n + 3'd1;
				end
				csed_pkg::PH_HEX1: begin
					push_bundle.bytes[n[1:0]] = csed_pkg::CH_BSLASH; n = n + 3'd1;
					push_bundle.bytes[n[1:0]] = csed_pkg::CH_LOW_X;  n = n + 3'd1;
					push_bundle.bytes[n[1:0]] = held_q;              n = n + 3'd1;
				end
				csed_pkg::PH_OCT: begin
					push_bundle.bytes[n[1:0]] = {2'd0, oval_q}; n = n + 3'd1;
				end
				default: n = 3'd0;
			endcase
			push_bundle.has_status = 1'b1;
			push_bundle.status     = bad_q || (c != csed_pkg::CH_QUOTE);
		end

		sum = {1'b0, cnt_q} + {10'd0, n};
		push_bundle.nbytes = n;
		push_bundle.count  = sum[12] ? csed_pkg::COUNT_MAX : sum[11:0];

		if (push_bundle.has_status) begin
			ph_nx   = csed_pkg::PH_START;
			held_nx = '0;
			oval_nx = '0;
			two_nx  = 1'b0;
			bad_nx  = 1'b0;
			cnt_nx  = '0;
		end else begin
			cnt_nx = push_bundle.count;
		end
	end

	assign push = acc && (push_bundle.has_status || (push_bundle.nbytes != 3'd0));

endmodule

FILE: src/csed_queue.sv
`timescale 1ns / 1ps

module csed_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csed_pkg::bundle_t  push_bundle,
	input  logic               pop,
	output csed_pkg::bundle_t  head,
	output logic               empty,
	output logic               full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	csed_pkg::bundle_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_push, do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign empty   = (fill_q == '0);
	assign full    = (fill_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (do_pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/csed_back.sv
`timescale 1ns / 1ps

module csed_back (
	input  logic                clk,
	input  logic                arst_n,
	input  csed_pkg::bundle_t   head,
	input  logic                q_empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output csed_pkg::out_item_t out_item
);

	logic [1:0]          idx_q;
	logic                ov_q;
	csed_pkg::out_item_t out_q;
	csed_pkg::out_item_t item;
	logic [2:0]          total;
	logic                last;
	logic                load;

	assign total = head.nbytes + {2'd0, head.has_status};
	assign last  = ({1'b0, idx_q} + 3'd1) == total;
	assign load  = (!ov_q || out_ready) && !q_empty;
	assign pop   = load && last;

	always_comb begin
		item = '0;
		if ({1'b0, idx_q} < head.nbytes) begin
			item.out_byte = head.bytes[idx_q];
		end else begin
			item.is_status  = 1'b1;
			item.status     = head.status;
			item.byte_count = head.count;
		end
		item.run_end = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
				ov_q  <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	assign out_valid = ov_q;
	assign out_item  = out_q;

endmodule

FILE: src/c_string_literal_escape_decoder_core.sv
`timescale 1ns / 1ps
// The results of an accepted character go into the queue, then to the output register.
// Throughput: one character per cycle in while the queue is not full, one result
// beat per cycle out while out_ready is high; the output register is the single
// result port, so a character's beats take turns while QUEUE_DEPTH entries absorb input.
// Reset: arst_n clears the decoder state, queue pointers and output valid at once.

module c_string_literal_escape_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csed_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output csed_pkg::out_item_t out_item
);

	// The front decodes each accepted character in the same cycle and produces
	// one bundle: up to four decoded bytes and, on the closing character, the
	// status beat with the saturated byte count. A character that yields
	// nothing (an opening quote, or the first characters of an escape) is not
	// queued at all.
	csed_pkg::bundle_t push_bundle;
	csed_pkg::bundle_t head;
	logic              push;
	logic              pop;
	logic              q_empty;
	logic              q_full;

	csed_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.q_full      (q_full),
		.push        (push),
		.push_bundle (push_bundle)
	);

	// The queue decouples the two sides: the front keeps taking characters
	// while the back drains a multi-beat expansion or waits on out_ready.
	csed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.head        (head),
		.empty       (q_empty),
		.full        (q_full)
	);

	// The back walks the head bundle one beat per cycle, while out_ready allows,
	// into the output register and marks the final beat of each bundle with run_end.
	csed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

FILE: src/csed_checker.sv
`timescale 1ns / 1ps

module csed_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input csed_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input csed_pkg::out_item_t out_item
);

	// A stalled input beat holds until the block takes it.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input beat changed while stalled");

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output beat changed while stalled");

	// The status beat always closes the run of its character and carries no byte.
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_status |-> out_item.run_end && out_item.out_byte == 8'd0)
		else $error("status beat malformed");

	// Byte beats carry no status information.
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_status |-> !out_item.status && out_item.byte_count == 12'd0)
		else $error("byte beat carries status fields");

	// The input side is ready in the cycle after reset, unless reset is still held.
	a_ready_after_reset: assert property (@(posedge clk)
		!arst_n |=> in_ready || !arst_n)
		else $error("not ready after reset");

endmodule

bind c_string_literal_escape_decoder_core csed_checker u_csed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// Characters of random tokens offered after the directed tokens.
	localparam int RANDOM_CHARS = 243;
	// Length in cycles of the long receiver hold-offs.
	localparam int LONG_HOLD = 400;

	// One character waiting to be offered. When drain is set, the sender holds the
	// character back until every result beat predicted so far has been received.
	typedef struct {
		csed_pkg::in_item_t item;
		bit                 drain;
	} feed_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	csed_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	csed_pkg::out_item_t out_item;

	// Characters still to be offered, and result beats predicted but not yet seen.
	feed_t               char_feed[$];
	csed_pkg::out_item_t due_beats[$];

	// Beats produced by the character being decoded right now.
	csed_pkg::out_item_t step_beats[$];

	// Content of the token being assembled by the stimulus code.
	logic [7:0] tok_body[$];

	// The eleven characters that form a simple escape after a backslash.
	logic [7:0] simple_esc [11] = '{"a", "b", "f", "n", "r", "t", "v",
		csed_pkg::CH_BSLASH, "'", csed_pkg::CH_QUOTE, "?"};

	// Decoder state of the predictor, one token at a time.
	csed_pkg::phase_t dec_phase = csed_pkg::PH_START;
	logic [7:0]       dec_held;
	logic [8:0]       dec_oct;
	logic [1:0]       dec_octn;
	logic             dec_bad_open;
	logic [11:0]      dec_count;

	int chars_queued = 0;
	int beats_checked = 0;
	int mismatches = 0;

	// Idle bookkeeping, each owned by one side.
	int tx_wait = 0;
	int tx_calm = 0;
	int rx_wait = 0;
	int rx_calm = 0;

	c_string_literal_escape_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor of the decoded stream.
	// ------------------------------------------------------------------

	// Returns the value of a hex digit, or 16 when the character is not one.
	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c - "0");
		end
		if (c >= "a" && c <= "f") begin
			return 10 + int'(c - "a");
		end
		if (c >= "A" && c <= "F") begin
			return 10 + int'(c - "A");
		end
		return 16;
	endfunction

	function automatic bit is_octal(logic [7:0] c);
		return c >= "0" && c <= "7";
	endfunction

	// Returns the decoder to its state between tokens.
	function automatic void token_clear();
		dec_phase    = csed_pkg::PH_START;
		dec_held     = '0;
		dec_oct      = '0;
		dec_octn     = '0;
		dec_bad_open = 1'b0;
		dec_count    = '0;
	endfunction

	// A decoded content byte; the count stops at its maximum instead of wrapping.
	function automatic void emit_byte(logic [7:0] b);
		csed_pkg::out_item_t beat;
		beat = '0;
		beat.out_byte = b;
		step_beats.push_back(beat);
		if (dec_count != csed_pkg::COUNT_MAX) begin
			dec_count++;
		end
	endfunction

	function automatic void emit_status(logic bad);
		csed_pkg::out_item_t beat;
		beat = '0;
		beat.is_status  = 1'b1;
		beat.status     = bad;
		beat.byte_count = dec_count;
		step_beats.push_back(beat);
	endfunction

	// Plain text: a backslash opens an escape, anything else passes through.
	function automatic void text_char(logic [7:0] c);
		if (c == csed_pkg::CH_BSLASH) begin
			dec_phase = csed_pkg::PH_ESC;
		end else begin
			dec_phase = csed_pkg::PH_TEXT;
			emit_byte(c);
		end
	endfunction

	// The character right after a backslash.
	function automatic void escape_char(logic [7:0] c);
		logic [7:0] m;
		bit         known;
		known = 1'b1;
		m = c;
		case (c)
			"a": m = 8'h07;
			"b": m = 8'h08;
			"f": m = 8'h0C;
			"n": m = 8'h0A;
			"r": m = 8'h0D;
			"t": m = 8'h09;
			"v": m = 8'h0B;
			csed_pkg::CH_BSLASH, "'", csed_pkg::CH_QUOTE, "?": m = c;
			default: known = 1'b0;
		endcase
		if (known) begin
			dec_phase = csed_pkg::PH_TEXT;
			emit_byte(m);
		end else if (c == csed_pkg::CH_LOW_X) begin
			dec_phase = csed_pkg::PH_HEX0;
		end else if (is_octal(c)) begin
			dec_oct   = {6'd0, c[2:0]};
			dec_octn  = 2'd1;
			dec_phase = csed_pkg::PH_OCT;
		end else begin
			// Unknown escape: the backslash is kept and the character is text again.
			emit_byte(csed_pkg::CH_BSLASH);
			text_char(c);
		end
	endfunction

	// One content character, that is neither the opener nor the closer.
	function automatic void content_char(logic [7:0] c);
		int         hi;
		int         lo;
		logic [7:0] hb;
		case (dec_phase)
			csed_pkg::PH_ESC: begin
				escape_char(c);
			end
			csed_pkg::PH_HEX0: begin
				if (hex_nibble(c) < 16) begin
					dec_held  = c;
					dec_phase = csed_pkg::PH_HEX1;
				end else begin
					// A broken hex escape is replayed as text, breaking character included.
					emit_byte(csed_pkg::CH_BSLASH);
					emit_byte(csed_pkg::CH_LOW_X);
					text_char(c);
				end
			end
			csed_pkg::PH_HEX1: begin
				if (hex_nibble(c) < 16) begin
					hi = hex_nibble(dec_held);
					lo = hex_nibble(c);
					hb = 8'(hi * 16 + lo);
					emit_byte(hb);
					dec_phase = csed_pkg::PH_TEXT;
				end else begin
					emit_byte(csed_pkg::CH_BSLASH);
					emit_byte(csed_pkg::CH_LOW_X);
					emit_byte(dec_held);
					text_char(c);
				end
				dec_held = '0;
			end
			csed_pkg::PH_OCT: begin
				if (is_octal(c)) begin
					dec_oct = {dec_oct[5:0], c[2:0]};
					dec_octn++;
					if (dec_octn == 2'd3) begin
						// Three digits close the escape; the value keeps its low 8 bits.
						emit_byte(dec_oct[7:0]);
						dec_oct   = '0;
						dec_octn  = '0;
						dec_phase = csed_pkg::PH_TEXT;
					end
				end else begin
					emit_byte(dec_oct[7:0]);
					dec_oct  = '0;
					dec_octn = '0;
					text_char(c);
				end
			end
			default: begin
				text_char(c);
			end
		endcase
	endfunction

	// The content ended while an escape was still open.
	function automatic void flush_escape();
		case (dec_phase)
			csed_pkg::PH_ESC: begin
				emit_byte(csed_pkg::CH_BSLASH);
			end
			csed_pkg::PH_HEX0: begin
				emit_byte(csed_pkg::CH_BSLASH);
				emit_byte(csed_pkg::CH_LOW_X);
			end
			csed_pkg::PH_HEX1: begin
				emit_byte(csed_pkg::CH_BSLASH);
				emit_byte(csed_pkg::CH_LOW_X);
				emit_byte(dec_held);
			end
			csed_pkg::PH_OCT: begin
				emit_byte(dec_oct[7:0]);
			end
			default: begin
			end
		endcase
	endfunction

	// Works out the result beats of one accepted character and queues them.
	function automatic void decode_char(csed_pkg::in_item_t it);
		step_beats.delete();
		if (dec_phase == csed_pkg::PH_START) begin
			if (it.last_char) begin
				// A token of one character is always malformed and has no content.
				emit_status(1'b1);
				token_clear();
			end else begin
				dec_bad_open = (it.ch != csed_pkg::CH_QUOTE);
				dec_phase    = csed_pkg::PH_TEXT;
			end
		end else if (!it.last_char) begin
			content_char(it.ch);
		end else begin
			// The last character is the closer whatever it is; only its value is judged.
			flush_escape();
			emit_status(dec_bad_open | (it.ch != csed_pkg::CH_QUOTE));
			token_clear();
		end
		if (step_beats.size() != 0) begin
			step_beats[step_beats.size() - 1].run_end = 1'b1;
		end
		foreach (step_beats[i]) begin
			due_beats.push_back(step_beats[i]);
		end
	endfunction

	// Compares one received beat, field by field, with the oldest prediction.
	function automatic void check_beat(csed_pkg::out_item_t got);
		csed_pkg::out_item_t want;
		beats_checked++;
		if (due_beats.size() == 0) begin
			$error("unexpected beat: out_byte %02h is_status %0b status %0b byte_count %0d",
				got.out_byte, got.is_status, got.status, got.byte_count);
			mismatches++;
		end else begin
			want = due_beats.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				mismatches++;
			end
			if (got.is_status !== want.is_status) begin
				$error("is_status: expected %0b, got %0b", want.is_status, got.is_status);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0b, got %0b", want.status, got.status);
				mismatches++;
			end
			if (got.byte_count !== want.byte_count) begin
				$error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
				mismatches++;
			end
			if (got.run_end !== want.run_end) begin
				$error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
				mismatches++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Idle pattern shared by both sides: mostly short gaps, a few long ones,
	// and now and then a run of beats with no gap at all.
	// ------------------------------------------------------------------
	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
		end
		if (r < 45) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction.
	// ------------------------------------------------------------------
	function automatic void add_char(logic [7:0] c, bit last, bit drain);
		feed_t f;
		f.item.ch        = c;
		f.item.last_char = last;
		f.drain          = drain;
		char_feed.push_back(f);
		chars_queued++;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			tok_body.push_back(s[i]);
		end
	endfunction

	// Queues opener, the collected content and the closer as one token.
	function automatic void add_token(logic [7:0] opener, logic [7:0] closer, bit drain);
		add_char(opener, 1'b0, drain);
		foreach (tok_body[i]) begin
			add_char(tok_body[i], 1'b0, 1'b0);
		end
		add_char(closer, 1'b1, 1'b0);
		tok_body.delete();
	endfunction

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	// Appends one piece of content. Escapes left open at the end of the content
	// are only produced for the last piece, where nothing can complete them.
	function automatic void add_piece(bit at_end);
		int         kind;
		int         n;
		logic [7:0] c;
		bit         known;
		kind = $urandom_range(0, at_end ? 7 : 6);
		case (kind)
			0: begin
				c = 8'($urandom_range(0, 255));
				tok_body.push_back(c);
			end
			1: begin
				c = 8'($urandom_range(8'h20, 8'h7E));
				tok_body.push_back(c);
			end
			2: begin
				tok_body.push_back(csed_pkg::CH_BSLASH);
				tok_body.push_back(simple_esc[$urandom_range(0, 10)]);
			end
			3: begin
				tok_body.push_back(csed_pkg::CH_BSLASH);
				tok_body.push_back(csed_pkg::CH_LOW_X);
				tok_body.push_back(hex_char());
				tok_body.push_back(hex_char());
			end
			4: begin
				// Hex escape broken after zero or one digit.
				tok_body.push_back(csed_pkg::CH_BSLASH);
				tok_body.push_back(csed_pkg::CH_LOW_X);
				if ($urandom_range(0, 1) == 1) begin
					tok_body.push_back(hex_char());
				end
				do begin
					c = 8'($urandom_range(0, 255));
				end while (hex_nibble(c) < 16);
				tok_body.push_back(c);
			end
			5: begin
				tok_body.push_back(csed_pkg::CH_BSLASH);
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					c = 8'("0" + $urandom_range(0, 7));
					tok_body.push_back(c);
				end
			end
			6: begin
				// Unknown escape: anything that is not simple, hex or octal.
				tok_body.push_back(csed_pkg::CH_BSLASH);
				do begin
					c = 8'($urandom_range(0, 255));
					known = (c == csed_pkg::CH_LOW_X) || is_octal(c);
					foreach (simple_esc[i]) begin
						if (simple_esc[i] == c) begin
							known = 1'b1;
						end
					end
				end while (known);
				tok_body.push_back(c);
			end
			default: begin
				// Lone backslash, or a hex escape cut short by the closer.
				tok_body.push_back(csed_pkg::CH_BSLASH);
				n = $urandom_range(0, 2);
				if (n >= 1) begin
					tok_body.push_back(csed_pkg::CH_LOW_X);
				end
				if (n == 2) begin
					tok_body.push_back(hex_char());
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers queued characters, keeps a beat stable until it is taken
	// and predicts each character at the edge where it is accepted.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			tx_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_char(in_item);
				tx_wait = next_gap(tx_calm);
			end else if (!in_valid && tx_wait > 0) begin
				tx_wait--;
			end
			// A beat on offer stays until it is accepted.
			if (!in_valid || in_ready) begin
				if (tx_wait == 0 && char_feed.size() != 0 &&
						!(char_feed[0].drain && due_beats.size() != 0)) begin
					in_item  <= char_feed[0].item;
					in_valid <= 1'b1;
					void'(char_feed.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks every accepted result beat and throttles out_ready.
	// Twice in the run it holds off for a long stretch so that the
	// block's queue fills and its input stalls while the driver keeps offering.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_beat(out_item);
				if (beats_checked == 60 || beats_checked == 140) begin
					rx_wait = LONG_HOLD;
				end else begin
					rx_wait = next_gap(rx_calm);
				end
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run.
	// ------------------------------------------------------------------
	initial begin
		int         random_start;
		int         r;
		int         n;
		bit         first;
		logic [7:0] opener;
		logic [7:0] closer;
		logic [7:0] c;

		token_clear();

		// A token of a single character.
		add_char(csed_pkg::CH_QUOTE, 1'b1, 1'b0);

		// Simple escape, good hex, hex broken after one digit, unknown escape,
		// three-digit octal whose value overflows 8 bits, one-digit octal ended by
		// text, and a closer that is not a quote.
		add_text("\\n\\x4F\\x4g\\q\\501\\7z");
		add_token(csed_pkg::CH_QUOTE, "'", 1'b0);

		// Bad opener, the extreme byte values and a trailing lone backslash.
		tok_body.push_back(8'h00);
		tok_body.push_back(8'hFF);
		tok_body.push_back(csed_pkg::CH_BSLASH);
		add_token("A", csed_pkg::CH_QUOTE, 1'b0);

		// Random tokens: mostly well formed with random escapes inside, some with a
		// bad opener or closer, and a few of a single character. The first one
		// waits until the directed tokens have drained completely.
		random_start = chars_queued;
		first = 1'b1;
		while (chars_queued - random_start < RANDOM_CHARS) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				c = 8'($urandom_range(0, 255));
				add_char(c, 1'b1, first);
			end else begin
				n = $urandom_range(0, 6);
				for (int k = 0; k < n; k++) begin
					add_piece(k == n - 1);
				end
				opener = csed_pkg::CH_QUOTE;
				closer = csed_pkg::CH_QUOTE;
				if (r < 12) begin
					opener = 8'($urandom_range(0, 255));
				end
				if (r >= 90) begin
					closer = 8'($urandom_range(0, 255));
				end
				add_token(opener, closer, first || ($urandom_range(0, 11) == 0));
			end
			first = 1'b0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_feed.size() != 0 || in_valid || due_beats.size() != 0) begin
			@(posedge clk);
		end
		// The extra wait catches any beat the block sends beyond the prediction.
		repeat (20) @(posedge clk);

		if (mismatches == 0 && due_beats.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog far beyond any correct run, including the slowest idle patterns.
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
